// ===== hdl/tfdd_pkg.sv =====
// Shared types and constants for the tiled frame difference detector.
// No dependencies; imported by the top level and the port checker.
package tfdd_pkg;

  // Default geometry limits and tile grid.
  localparam int DefMaxThumbWidth  = 64;
  localparam int DefMaxThumbHeight = 64;
  localparam int DefTilesX         = 8;
  localparam int DefTilesY         = 8;

  // Configuration register indexes.
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_THUMB_WIDTH   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_THUMB_HEIGHT  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DUP_THRESHOLD = 2'd2;

  localparam logic [6:0]  RST_THUMB_WIDTH   = 7'd64;
  localparam logic [6:0]  RST_THUMB_HEIGHT  = 7'd36;
  localparam logic [15:0] RST_DUP_THRESHOLD = 16'd256;

  // Largest absolute RGB difference of one pixel, and largest tile mean (8.8).
  localparam int          PixDiffMax = 3 * 255;
  localparam logic [15:0] MEAN_MAX   = 16'hFF00;

  typedef enum logic [6:0] {
    ST_INIT = 7'b0000001,
    ST_ADV  = 7'b0000010,
    ST_IDLE = 7'b0000100,
    ST_DIFF = 7'b0001000,
    ST_MUL  = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_STEP = 7'b1000000
  } tfdd_state_e;

endpackage

// ===== hdl/tiled_frame_difference_detector_unit.sv =====
// Top level of the tiled frame difference detector: pixel store, tile
// bookkeeping and frame verdict. Uses tfdd_pkg and tfdd_div.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid_i/in_ready_o  red_i, green_i, blue_i
//   out      source     out_valid_o/out_ready_i duplicate_o, compared_o,
//                                              max_difference_o
//   cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Each pixel passes through accept with store read/write, difference, counter
// step and tile bound check; the bound check repeats for each empty tile skipped,
// with column and row skips running side by side.
// A pixel that closes a tile also passes through the divider start state and
// the serial mean divider. After reset and after each register write, the
// geometry setup runs an init state and the tile bound check, plus any empty tile skips.
// The result sits in an output register; pixels keep flowing while it waits,
// except the last pixel of the next frame, which holds until it is taken.
module tiled_frame_difference_detector_unit
  import tfdd_pkg::*;
#(
  parameter int MAX_THUMB_WIDTH  = DefMaxThumbWidth,
  parameter int MAX_THUMB_HEIGHT = DefMaxThumbHeight,
  parameter int TILES_X          = DefTilesX,
  parameter int TILES_Y          = DefTilesY
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               duplicate_o,
  output logic               compared_o,
  output logic [15:0]        max_difference_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int CW    = $clog2(MAX_THUMB_WIDTH + 1);
  localparam int RW    = $clog2(MAX_THUMB_HEIGHT + 1);
  localparam int XBW   = $clog2((MAX_THUMB_WIDTH + 2) * TILES_X + 1);
  localparam int YBW   = $clog2((MAX_THUMB_HEIGHT + 2) * TILES_Y + 1);
  localparam int TXW   = (TILES_X > 1) ? $clog2(TILES_X) : 1;
  localparam int DEPTH = MAX_THUMB_WIDTH * MAX_THUMB_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = $clog2(DEPTH * PixDiffMax + 1);
  localparam int NW    = SW + 8;
  localparam int PW    = CW + RW;
  localparam int DW    = PW + 2;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  tfdd_state_e st_q, st_d;

  // Configuration registers.
  logic [6:0]  thumb_width_q;
  logic [6:0]  thumb_height_q;
  logic [15:0] dup_threshold_q;
  logic        cfg_we;

  // Frame position and tile bookkeeping.
  logic [CW-1:0]  col_q;
  logic [RW-1:0]  row_q;
  logic [AW-1:0]  addr_q;
  logic [AW-1:0]  row_base_q;
  logic [XBW-1:0] cs_q;     // (col+1)*TILES_X
  logic [XBW-1:0] bnd_q;    // w*(tx+1)
  logic [YBW-1:0] rs_q;     // (row+1)*TILES_Y
  logic [YBW-1:0] rbnd_q;   // h*(ty+1)
  logic [TXW-1:0] tx_q;
  logic [CW-1:0]  xs_q;     // first column of current column tile
  logic [RW-1:0]  ys_q;     // first row of current row tile
  logic           prev_valid_q;
  logic [15:0]    running_max_q;
  logic [SW-1:0]  tsum_q [TILES_X];

  // Per-pixel datapath.
  logic [7:0]    r_q, g_q, b_q;
  logic [23:0]   rd_q;
  logic [PW-1:0] prod_q;
  logic [NW-1:0] dividend_q;

  // Result register.
  logic        out_valid_q;
  logic        duplicate_q;
  logic        compared_q;
  logic [15:0] max_diff_q;

  logic [CW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  logic          last_col, last_row, col_end, row_end;
  logic          in_acc;
  logic [9:0]    pix_diff;
  logic [SW-1:0] sum_new;
  logic [CW-1:0] tile_w;
  logic [RW-1:0] tile_h;
  logic          div_start, div_done;
  logic [NW-1:0] div_quo;
  logic [15:0]   mean;

  logic [23:0] pix_mem [DEPTH];

  always_comb begin
    if (thumb_width_q == '0) begin
      w_eff = CW'(1);
    end else if (32'(thumb_width_q) > 32'(MAX_THUMB_WIDTH)) begin
      w_eff = CW'(MAX_THUMB_WIDTH);
    end else begin
      w_eff = CW'(thumb_width_q);
    end
    if (thumb_height_q == '0) begin
      h_eff = RW'(1);
    end else if (32'(thumb_height_q) > 32'(MAX_THUMB_HEIGHT)) begin
      h_eff = RW'(MAX_THUMB_HEIGHT);
    end else begin
      h_eff = RW'(thumb_height_q);
    end
  end

  assign last_col = (col_q + CW'(1)) == w_eff;
  assign last_row = (row_q + RW'(1)) == h_eff;
  // The next column (row) falls beyond the current tile's bound.
  assign col_end  = ((XBW + 1)'(cs_q) + (XBW + 1)'(TILES_X)) > (XBW + 1)'(bnd_q);
  assign row_end  = ((YBW + 1)'(rs_q) + (YBW + 1)'(TILES_Y)) > (YBW + 1)'(rbnd_q);

  assign cfg_ready_o = 1'b1;
  assign cfg_we = cfg_valid_i && (cfg_index_i == REG_THUMB_WIDTH ||
                                  cfg_index_i == REG_THUMB_HEIGHT ||
                                  cfg_index_i == REG_DUP_THRESHOLD);

  // Hold the last pixel of a frame while the previous verdict is still pending.
  assign in_ready_o = (st_q == ST_IDLE) && !(out_valid_q && last_col && last_row);
  assign in_acc     = in_valid_i && in_ready_o;

  assign pix_diff = 10'(abs_diff(r_q, rd_q[23:16])) + 10'(abs_diff(g_q, rd_q[15:8]))
                  + 10'(abs_diff(b_q, rd_q[7:0]));
  assign sum_new  = tsum_q[tx_q] + SW'(pix_diff);
  assign tile_w   = col_q - xs_q + CW'(1);
  assign tile_h   = row_q - ys_q + RW'(1);

  assign div_start = (st_q == ST_MUL);
  assign mean = (div_quo > NW'(MEAN_MAX)) ? MEAN_MAX : div_quo[15:0];

  tfdd_div #(
    .NumW (NW),
    .DenW (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend_q),
    .divisor_i  (DW'({prod_q, 1'b0}) + DW'(prod_q)),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Read-first pixel store: old pixel out, new pixel in, same address.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q            <= pix_mem[addr_q];
      pix_mem[addr_q] <= {red_i, green_i, blue_i};
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_INIT: st_d = ST_ADV;
      ST_ADV: begin
        if (!(cs_q > bnd_q) && !(rs_q > rbnd_q)) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          st_d = ST_DIFF;
        end
      end
      ST_DIFF: st_d = (prev_valid_q && col_end && row_end) ? ST_MUL : ST_STEP;
      ST_MUL:  st_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          st_d = ST_STEP;
        end
      end
      ST_STEP: st_d = ST_ADV;
      default: st_d = ST_INIT;
    endcase
    if (cfg_we) begin
      st_d = ST_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q            <= ST_INIT;
      thumb_width_q   <= RST_THUMB_WIDTH;
      thumb_height_q  <= RST_THUMB_HEIGHT;
      dup_threshold_q <= RST_DUP_THRESHOLD;
      prev_valid_q    <= 1'b0;
      running_max_q   <= '0;
      out_valid_q     <= 1'b0;
      col_q           <= '0;
      row_q           <= '0;
      addr_q          <= '0;
      row_base_q      <= '0;
      cs_q            <= '0;
      bnd_q           <= '0;
      rs_q            <= '0;
      rbnd_q          <= '0;
      tx_q            <= '0;
      xs_q            <= '0;
      ys_q            <= '0;
      for (int i = 0; i < TILES_X; i++) begin
        tsum_q[i] <= '0;
      end
    end else begin
      st_q <= st_d;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we) begin
        prev_valid_q <= 1'b0;
        unique case (cfg_index_i)
          REG_THUMB_WIDTH:   thumb_width_q   <= cfg_data_i[6:0];
          REG_THUMB_HEIGHT:  thumb_height_q  <= cfg_data_i[6:0];
          default:           dup_threshold_q <= cfg_data_i;
        endcase
      end
      unique case (st_q)
        ST_INIT: begin
          col_q         <= '0;
          row_q         <= '0;
          addr_q        <= '0;
          row_base_q    <= '0;
          cs_q          <= XBW'(TILES_X);
          bnd_q         <= XBW'(w_eff);
          rs_q          <= YBW'(TILES_Y);
          rbnd_q        <= YBW'(h_eff);
          tx_q          <= '0;
          xs_q          <= '0;
          ys_q          <= '0;
          running_max_q <= '0;
          for (int i = 0; i < TILES_X; i++) begin
            tsum_q[i] <= '0;
          end
        end
        ST_ADV: begin
          // Skip ahead to the tile that holds the next column and row.
          if (cs_q > bnd_q) begin
            tx_q  <= tx_q + TXW'(1);
            bnd_q <= bnd_q + XBW'(w_eff);
          end
          if (rs_q > rbnd_q) begin
            rbnd_q <= rbnd_q + YBW'(h_eff);
          end
        end
        ST_DIFF: begin
          if (prev_valid_q) begin
            tsum_q[tx_q] <= (col_end && row_end) ? '0 : sum_new;
          end
        end
        ST_DIV: begin
          if (div_done && (mean > running_max_q)) begin
            running_max_q <= mean;
          end
        end
        ST_STEP: begin
          if (last_col) begin
            col_q <= '0;
            cs_q  <= XBW'(TILES_X);
            bnd_q <= XBW'(w_eff);
            tx_q  <= '0;
            xs_q  <= '0;
            if (last_row) begin
              row_q         <= '0;
              rs_q          <= YBW'(TILES_Y);
              rbnd_q        <= YBW'(h_eff);
              ys_q          <= '0;
              addr_q        <= '0;
              row_base_q    <= '0;
              out_valid_q   <= 1'b1;
              prev_valid_q  <= 1'b1;
              running_max_q <= '0;
            end else begin
              row_q      <= row_q + RW'(1);
              rs_q       <= rs_q + YBW'(TILES_Y);
              addr_q     <= row_base_q + AW'(MAX_THUMB_WIDTH);
              row_base_q <= row_base_q + AW'(MAX_THUMB_WIDTH);
              if (row_end) begin
                ys_q <= row_q + RW'(1);
              end
            end
          end else begin
            col_q  <= col_q + CW'(1);
            cs_q   <= cs_q + XBW'(TILES_X);
            addr_q <= addr_q + AW'(1);
            if (col_end) begin
              xs_q <= col_q + CW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      r_q <= red_i;
      g_q <= green_i;
      b_q <= blue_i;
    end
    if (st_q == ST_DIFF) begin
      prod_q     <= PW'(tile_w) * PW'(tile_h);
      dividend_q <= {sum_new, 8'd0};
    end
    if (st_q == ST_STEP && last_col && last_row) begin
      compared_q  <= prev_valid_q;
      duplicate_q <= prev_valid_q && (running_max_q <= dup_threshold_q);
      max_diff_q  <= prev_valid_q ? running_max_q : 16'd0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign duplicate_o      = duplicate_q;
  assign compared_o       = compared_q;
  assign max_difference_o = max_diff_q;

endmodule

// ===== hdl/tfdd_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; instantiated by tiled_frame_difference_detector_unit.
module tfdd_div #(
  parameter int NumW = 30,
  parameter int DenW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] dividend_i,
  input  logic [DenW-1:0] divisor_i,
  output logic            done_o,
  output logic [NumW-1:0] quotient_o
);

  localparam int CntW = $clog2(NumW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [DenW-1:0] rem_q;
  logic [DenW-1:0] den_q;
  logic [NumW-1:0] quo_q;

  logic [DenW:0]   rem_sh;
  logic [DenW:0]   rem_sub;
  logic            fits;

  // Shift the next dividend bit into the partial remainder, subtract if it fits.
  assign rem_sh  = {rem_q, quo_q[NumW-1]};
  assign fits    = rem_sh >= {1'b0, den_q};
  assign rem_sub = fits ? (rem_sh - {1'b0, den_q}) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_sub[DenW-1:0];
      quo_q <= {quo_q[NumW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== hdl/tfdd_checker.sv =====
// Port-level checks for tiled_frame_difference_detector_unit, bound to it.
// Uses tfdd_pkg for register indexes and the mean limit.
module tfdd_checker
  import tfdd_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               duplicate_o,
  input logic               compared_o,
  input logic [15:0]        max_difference_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [CfgIdxW-1:0] cfg_index_i
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(duplicate_o)
      && $stable(compared_o) && $stable(max_difference_o))
    else $error("stalled result changed");

  a_dup_needs_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && duplicate_o |-> compared_o)
    else $error("duplicate without comparison");

  a_nocmp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !compared_o |-> max_difference_o == 16'd0)
    else $error("uncompared frame with nonzero difference");

  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> max_difference_o <= MEAN_MAX)
    else $error("tile mean out of range");

  // A register write restarts the frame, so no item is taken right after it.
  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o && (cfg_index_i == REG_THUMB_WIDTH ||
      cfg_index_i == REG_THUMB_HEIGHT || cfg_index_i == REG_DUP_THRESHOLD)
    |=> !in_ready_o)
    else $error("item taken during frame restart");

endmodule

bind tiled_frame_difference_detector_unit tfdd_checker u_tfdd_checker (.*);
